[rtl/zmtc_pkg.sv]
// ----------------------------------------------------------------------------
// zmtc_pkg
// Shared constants, codes and types of the zero-mean template correlator.
// ----------------------------------------------------------------------------
package zmtc_pkg;

  localparam int TR        = 15;
  localparam int TC        = 9;
  localparam int MAX_COLS  = 1024;
  localparam int ROW_LIMIT = 1024;
  localparam int TAPS      = TR * TC;

  localparam int CFG_W   = 11;
  localparam int SUM_W   = 25;
  localparam int POS_W   = 10;
  localparam int TAP_AW  = $clog2(TAPS);
  localparam int RING_W  = $clog2(TR);
  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int CCNT_W  = $clog2(MAX_COLS + 1);
  localparam int RCNT_W  = $clog2(ROW_LIMIT + 1);
  localparam int CJ_W    = $clog2(TC);
  localparam int TOT_W   = $clog2(TAPS * 255 + 1);
  localparam int ACC_W   = $clog2(TAPS * 255 * 255 + 1) + 2;
  localparam int RNG_W   = SUM_W + 1;
  localparam int DIV_W   = RNG_W + 8;
  localparam int DCNT_W  = $clog2(DIV_W + 1);

  localparam int MEAN_SHIFT = 2 * TAP_AW + 8;
  localparam int MUL_W      = MEAN_SHIFT - TAP_AW + 2;
  localparam logic [63:0] MEAN_MUL_L = ((64'd1 << MEAN_SHIFT) + TAPS - 1) / TAPS;
  localparam logic [MUL_W-1:0] MEAN_MUL = MEAN_MUL_L[MUL_W-1:0];

  localparam logic signed [ACC_W-1:0] SUM_MAX = ACC_W'((1 << (SUM_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SUM_MIN = -ACC_W'(1 << (SUM_W - 1));

  typedef enum logic [1:0] {
    KIND_TMPL = 2'd0,
    KIND_PIX  = 2'd1,
    KIND_NORM = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic {
    CFG_COLS = 1'b0,
    CFG_ROWS = 1'b1
  } cfg_e;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_PIX  = 2'd1,
    OP_NORM = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic [7:0]               pixel;
    logic                     first;
    logic                     last;
    logic [TAP_AW-1:0]        taddr;
    logic [RING_W-1:0]        ring;
    logic [COL_W-1:0]         col;
    logic [POS_W-1:0]         crow;
    logic [POS_W-1:0]         ccol;
    logic                     clear;
    logic                     emit;
    logic signed [SUM_W-1:0]  raw_sum;
  } cmd_t;

endpackage

[rtl/zmtc_front.sv]
// ----------------------------------------------------------------------------
// zmtc_front
// Accept items, track template and image position, issue commands.
// ----------------------------------------------------------------------------
module zmtc_front import zmtc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              kind_i,
  input  logic [7:0]              pixel_i,
  input  logic signed [SUM_W-1:0] raw_sum_i,
  input  logic                    frame_start_i,
  input  logic                    q_full_i,
  output logic                    push_o,
  output cmd_t                    cmd_o
);

  localparam int CMP_W = (CFG_W > RCNT_W) ? ((CFG_W > CCNT_W) ? CFG_W : CCNT_W)
                                          : ((RCNT_W > CCNT_W) ? RCNT_W : CCNT_W);

  logic [CFG_W-1:0]  cols_cfg_q, rows_cfg_q;
  logic [CMP_W-1:0]  cols, rows;
  logic [TAP_AW:0]   tcnt_q, tcnt_d;
  logic [CCNT_W-1:0] col_q, col_d;
  logic [RCNT_W-1:0] row_q, row_d;
  logic [RING_W-1:0] ring_q, ring_d;
  logic [CCNT_W-1:0] c;
  logic [RCNT_W-1:0] r;
  logic [RING_W-1:0] rg;
  logic [TAP_AW:0]   tc;
  logic              accept;

  always_comb begin
    if (cols_cfg_q == '0) cols = CMP_W'(1);
    else if (CMP_W'(cols_cfg_q) > CMP_W'(MAX_COLS)) cols = CMP_W'(MAX_COLS);
    else cols = CMP_W'(cols_cfg_q);
    if (rows_cfg_q == '0) rows = CMP_W'(1);
    else if (CMP_W'(rows_cfg_q) > CMP_W'(ROW_LIMIT)) rows = CMP_W'(ROW_LIMIT);
    else rows = CMP_W'(rows_cfg_q);
  end

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    tcnt_d = tcnt_q;
    col_d  = col_q;
    row_d  = row_q;
    ring_d = ring_q;
    push_o = 1'b0;
    cmd_o  = '0;
    cmd_o.op      = OP_NOP;
    cmd_o.pixel   = pixel_i;
    cmd_o.raw_sum = raw_sum_i;
    tc = frame_start_i ? '0 : tcnt_q;
    c  = frame_start_i ? '0 : col_q;
    r  = frame_start_i ? '0 : row_q;
    rg = frame_start_i ? '0 : ring_q;
    if (accept) begin
      unique case (kind_e'(kind_i))
        KIND_TMPL: begin
          tcnt_d = tc;
          if (tc < (TAP_AW+1)'(TAPS)) begin
            push_o       = 1'b1;
            cmd_o.op     = OP_LOAD;
            cmd_o.first  = frame_start_i;
            cmd_o.last   = (tc == (TAP_AW+1)'(TAPS - 1));
            cmd_o.taddr  = tc[TAP_AW-1:0];
            tcnt_d       = tc + 1'b1;
          end
        end
        KIND_PIX: begin
          col_d  = c;
          row_d  = r;
          ring_d = rg;
          if (CMP_W'(r) < rows) begin
            if (CMP_W'(c) >= cols) c = '0;
            push_o      = 1'b1;
            cmd_o.op    = OP_PIX;
            cmd_o.ring  = rg;
            cmd_o.col   = c[COL_W-1:0];
            cmd_o.crow  = POS_W'(r - RCNT_W'(TR / 2));
            cmd_o.ccol  = POS_W'(c - CCNT_W'(TC / 2));
            cmd_o.clear = frame_start_i;
            cmd_o.emit  = (r >= RCNT_W'(TR - 1)) && (c >= CCNT_W'(TC - 1));
            if (CMP_W'(c + 1'b1) >= cols) begin
              col_d  = '0;
              row_d  = r + 1'b1;
              ring_d = (rg == RING_W'(TR - 1)) ? '0 : rg + 1'b1;
            end else begin
              col_d = c + 1'b1;
            end
          end
        end
        KIND_NORM: begin
          push_o   = 1'b1;
          cmd_o.op = OP_NORM;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_cfg_q <= CFG_W'(512);
      rows_cfg_q <= CFG_W'(512);
      tcnt_q     <= '0;
      col_q      <= '0;
      row_q      <= '0;
      ring_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_e'(cfg_idx_i))
          CFG_COLS: cols_cfg_q <= cfg_data_i;
          CFG_ROWS: rows_cfg_q <= cfg_data_i;
          default:  ;
        endcase
      end
      tcnt_q <= tcnt_d;
      col_q  <= col_d;
      row_q  <= row_d;
      ring_q <= ring_d;
    end
  end

endmodule

[rtl/zmtc_queue.sv]
// ----------------------------------------------------------------------------
// zmtc_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module zmtc_queue import zmtc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign cmd_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

[rtl/zmtc_back.sv]
// ----------------------------------------------------------------------------
// zmtc_back
// Execute commands: template store, line store, serial MAC and divider.
// ----------------------------------------------------------------------------
module zmtc_back import zmtc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     empty_i,
  input  cmd_t                     cmd_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     out_kind_o,
  output logic signed [SUM_W-1:0]  corr_sum_o,
  output logic [POS_W-1:0]         centre_row_o,
  output logic [POS_W-1:0]         centre_col_o,
  output logic [7:0]               norm_pixel_o,
  output logic                     range_zero_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MEAN  = 8'b0000_0010,
    S_CORR  = 8'b0000_0100,
    S_DRAIN = 8'b0000_1000,
    S_FIN   = 8'b0001_0000,
    S_NPREP = 8'b0010_0000,
    S_NDIV  = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [7:0]  tmem [TAPS];
  logic [7:0]  lmem [TR*MAX_COLS];

  logic [TOT_W-1:0]        tot_q, tot_d;
  logic [7:0]              mean_q, mean_d;
  logic [TOT_W+MUL_W-1:0]  mprod;
  logic [TAP_AW-1:0]       ti_q, ti_d;
  logic [RING_W-1:0]       ri_q, ri_d;
  logic [CJ_W-1:0]         cj_q, cj_d;
  logic [COL_W-1:0]        base_q, base_d;
  logic [7:0]              tdat_q, ldat_q;
  logic                    v1_q, v2_q;
  logic signed [8:0]       tap;
  logic signed [17:0]      prod_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [SUM_W-1:0] max_q, max_d, min_q, min_d, sat;
  logic signed [SUM_W-1:0] s_q, s_d;
  logic signed [RNG_W-1:0] rng, num;
  logic [RNG_W-1:0]        rng_q, rng_d, rem_q, rem_d, sh;
  logic [DIV_W-1:0]        div_q, div_d;
  logic [DCNT_W-1:0]       cnt_q, cnt_d;
  logic [POS_W-1:0]        crow_q, crow_d, ccol_q, ccol_d;
  logic                    rk_q, rk_d, rz_q, rz_d;
  logic signed [SUM_W-1:0] rs_q, rs_d;
  logic [7:0]              rn_q, rn_d;
  logic                    ov_q, ov_d;
  logic                    tmem_we, lmem_we;

  assign pop_o = (state_q == S_IDLE) && !empty_i;
  assign tmem_we = pop_o && (cmd_i.op == OP_LOAD);
  assign lmem_we = pop_o && (cmd_i.op == OP_PIX);
  assign mprod = tot_q * MEAN_MUL;
  assign tap = $signed({1'b0, tdat_q}) - $signed({1'b0, mean_q});
  assign rng = RNG_W'(max_q) - RNG_W'(min_q);
  assign num = RNG_W'(s_q) - RNG_W'(min_q);
  assign sh  = {rem_q[RNG_W-2:0], div_q[DIV_W-1]};

  always_ff @(posedge clk_i) begin
    if (tmem_we) tmem[cmd_i.taddr] <= cmd_i.pixel;
    if (lmem_we) lmem[{cmd_i.ring, cmd_i.col}] <= cmd_i.pixel;
    tdat_q <= tmem[ti_q];
    ldat_q <= lmem[{ri_q, base_q + COL_W'(cj_q)}];
    prod_q <= tap * $signed({1'b0, ldat_q});
  end

  always_comb begin
    state_d = state_q;
    tot_d = tot_q;   mean_d = mean_q;
    ti_d = ti_q;     ri_d = ri_q;     cj_d = cj_q;   base_d = base_q;
    acc_d = acc_q;   max_d = max_q;   min_d = min_q; s_d = s_q;
    rng_d = rng_q;   rem_d = rem_q;   div_d = div_q; cnt_d = cnt_q;
    crow_d = crow_q; ccol_d = ccol_q;
    rk_d = rk_q; rz_d = rz_q; rs_d = rs_q; rn_d = rn_q;
    ov_d = ov_q && out_stall_i;
    sat = '0;
    if (v2_q) acc_d = acc_q + ACC_W'(prod_q);
    unique case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          unique case (cmd_i.op)
            OP_LOAD: begin
              tot_d = (cmd_i.first ? '0 : tot_q) + TOT_W'(cmd_i.pixel);
              if (cmd_i.last) state_d = S_MEAN;
            end
            OP_PIX: begin
              if (cmd_i.clear) begin
                max_d = '0;
                min_d = '0;
              end
              ti_d   = '0;
              cj_d   = '0;
              ri_d   = (cmd_i.ring == RING_W'(TR - 1)) ? '0 : cmd_i.ring + 1'b1;
              base_d = cmd_i.col - COL_W'(TC - 1);
              acc_d  = '0;
              crow_d = cmd_i.crow;
              ccol_d = cmd_i.ccol;
              if (cmd_i.emit) state_d = S_CORR;
            end
            OP_NORM: begin
              s_d     = cmd_i.raw_sum;
              state_d = S_NPREP;
            end
            default: ;
          endcase
        end
      end
      S_MEAN: begin
        mean_d  = mprod[MEAN_SHIFT+7:MEAN_SHIFT];
        state_d = S_IDLE;
      end
      S_CORR: begin
        ti_d = ti_q + 1'b1;
        if (cj_q == CJ_W'(TC - 1)) begin
          cj_d = '0;
          ri_d = (ri_q == RING_W'(TR - 1)) ? '0 : ri_q + 1'b1;
        end else begin
          cj_d = cj_q + 1'b1;
        end
        if (ti_q == TAP_AW'(TAPS - 1)) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (!v1_q && !v2_q) state_d = S_FIN;
      end
      S_FIN: begin
        priority if (acc_q > SUM_MAX) sat = SUM_MAX[SUM_W-1:0];
        else if (acc_q < SUM_MIN)     sat = SUM_MIN[SUM_W-1:0];
        else                          sat = acc_q[SUM_W-1:0];
        if (max_q < sat) max_d = sat;
        if (min_q > sat) min_d = sat;
        rk_d = 1'b0; rs_d = sat; rn_d = '0; rz_d = 1'b0;
        state_d = S_EMIT;
      end
      S_NPREP: begin
        rk_d = 1'b1; rs_d = '0; rz_d = 1'b0; rn_d = '0;
        crow_d = '0; ccol_d = '0;
        rng_d = rng;
        rem_d = '0;
        div_d = {num, 8'b0} - DIV_W'(num);
        cnt_d = DCNT_W'(DIV_W);
        priority if (rng == '0) begin
          rz_d = 1'b1;
          state_d = S_EMIT;
        end else if (num <= 0) begin
          state_d = S_EMIT;
        end else if (num >= rng) begin
          rn_d = 8'd255;
          state_d = S_EMIT;
        end else begin
          state_d = S_NDIV;
        end
      end
      S_NDIV: begin
        if (sh >= rng_q) begin
          rem_d = sh - rng_q;
          div_d = {div_q[DIV_W-2:0], 1'b1};
        end else begin
          rem_d = sh;
          div_d = {div_q[DIV_W-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == DCNT_W'(1)) begin
          rn_d = div_d[7:0];
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tot_q   <= '0;
      mean_q  <= '0;
      max_q   <= '0;
      min_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      tot_q   <= tot_d;
      mean_q  <= mean_d;
      max_q   <= max_d;
      min_q   <= min_d;
      v1_q    <= (state_q == S_CORR);
      v2_q    <= v1_q;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ti_q <= ti_d; ri_q <= ri_d; cj_q <= cj_d; base_q <= base_d;
    acc_q <= acc_d; s_q <= s_d; rng_q <= rng_d; rem_q <= rem_d;
    div_q <= div_d; cnt_q <= cnt_d; crow_q <= crow_d; ccol_q <= ccol_d;
    rk_q <= rk_d; rz_q <= rz_d; rs_q <= rs_d; rn_q <= rn_d;
    if ((state_q == S_EMIT) && (!ov_q || !out_stall_i)) begin
      out_kind_o   <= rk_q;
      corr_sum_o   <= rs_q;
      centre_row_o <= rk_q ? '0 : crow_q;
      centre_col_o <= rk_q ? '0 : ccol_q;
      norm_pixel_o <= rn_q;
      range_zero_o <= rz_q;
    end
  end

  assign out_valid_o = ov_q;

endmodule

[rtl/zero_mean_template_correlator.sv]
// ----------------------------------------------------------------------------
// zero_mean_template_correlator
// Matched spatial filter with a zero-mean 15x9 template.
// ----------------------------------------------------------------------------
// An image pixel that completes a window runs one multiply-accumulate per
// template tap through a single shared MAC fed by the template and line
// memories, then drains the pipeline and finishes. A normalize request that
// needs a division uses a one-bit-per-cycle divider. The template mean is
// computed in a state after the last tap. Commands wait in a two-entry
// queue, so input is taken while the back end works, until the queue fills.
// Line width must stay a power of two in MAX_COLS for line store addressing.
module zero_mean_template_correlator import zmtc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               kind_i,
  input  logic [7:0]               pixel_i,
  input  logic signed [SUM_W-1:0]  raw_sum_i,
  input  logic                     frame_start_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     out_kind_o,
  output logic signed [SUM_W-1:0]  corr_sum_o,
  output logic [POS_W-1:0]         centre_row_o,
  output logic [POS_W-1:0]         centre_col_o,
  output logic [7:0]               norm_pixel_o,
  output logic                     range_zero_o
);

  logic  q_push, q_pop, q_full, q_empty;
  cmd_t  f_cmd, b_cmd;

  zmtc_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .kind_i, .pixel_i, .raw_sum_i, .frame_start_i,
    .q_full_i (q_full),
    .push_o   (q_push),
    .cmd_o    (f_cmd)
  );

  zmtc_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (q_push),
    .cmd_i   (f_cmd),
    .pop_i   (q_pop),
    .cmd_o   (b_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  zmtc_back u_back (
    .clk_i, .rst_ni,
    .empty_i (q_empty),
    .cmd_i   (b_cmd),
    .pop_o   (q_pop),
    .out_valid_o, .out_stall_i, .out_kind_o, .corr_sum_o,
    .centre_row_o, .centre_col_o, .norm_pixel_o, .range_zero_o
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_push) else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_empty |-> !q_pop) else $error("pop from empty queue");

  a_raw_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_kind_o) |-> (norm_pixel_o == 8'd0 && !range_zero_o))
    else $error("raw result carries normalize fields");

  a_zero_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_zero_o) |-> (out_kind_o && norm_pixel_o == 8'd0))
    else $error("zero range with nonzero byte");

endmodule

[verif/zero_mean_template_correlator_tb.sv]
// ----------------------------------------------------------------------------
// zero_mean_template_correlator_tb
// Self-checking bench for the zero-mean template correlator. A short table of
// directed words comes first, then fixed and randomized phases: template loads
// (full, partial, overflowing), image frames of small and extreme sizes with
// ignored trailing pixels, and normalize requests. Each accepted word runs
// through a local model of the filter. Every returned word is checked field
// by field against the oldest pending expectation. Both handshakes idle at
// random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module zero_mean_template_correlator_tb import zmtc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2500000;
  localparam int DRAIN_WAIT  = 300;

  typedef struct packed {
    logic                    kind;
    logic signed [SUM_W-1:0] sum;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic [7:0]              norm;
    logic                    zero;
  } result_t;

  typedef struct packed {
    kind_e                   kind;
    logic [7:0]              pix;
    logic signed [SUM_W-1:0] sum;
    logic                    fs;
    logic                    typed;
    result_t                 res;
  } stim_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic                    cfg_idx_i = 1'b0;
  logic [CFG_W-1:0]        cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [1:0]              kind_i = KIND_NONE;
  logic [7:0]              pixel_i = '0;
  logic signed [SUM_W-1:0] raw_sum_i = '0;
  logic                    frame_start_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b1;
  logic                    out_kind_o;
  logic signed [SUM_W-1:0] corr_sum_o;
  logic [POS_W-1:0]        centre_row_o;
  logic [POS_W-1:0]        centre_col_o;
  logic [7:0]              norm_pixel_o;
  logic                    range_zero_o;

  zero_mean_template_correlator uut (.*);

  always #5 clk_i = ~clk_i;

  // filter model state
  logic [7:0]  tmpl_mem [TAPS];
  logic [7:0]  line_mem [TR*MAX_COLS];
  int unsigned tmpl_total, tmpl_mean, tmpl_cnt, row_cnt, col_cnt;
  longint      peak_max, peak_min;
  logic [CFG_W-1:0] cols_reg = 11'd512, rows_reg = 11'd512;

  result_t expected_q [$];
  int      errors = 0;
  int      cycles = 0;
  int      words_sent = 0;
  bit      typed_now = 1'b0;
  result_t typed_res;
  bit      tx_idle = 1'b1, rx_idle = 1'b1, hold_req = 1'b0;

  function automatic int unsigned clamp_reg(logic [CFG_W-1:0] v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit filter_step(logic [1:0] kind, logic [7:0] pix,
                                     logic signed [SUM_W-1:0] rsum, logic fs,
                                     output result_t r);
    int unsigned cols, rows, rr, cc;
    longint acc, s, rng, num, q;
    r = '0;
    case (kind)
      KIND_TMPL: begin
        if (fs) begin
          tmpl_cnt = 0;
          tmpl_total = 0;
        end
        if (tmpl_cnt < TAPS) begin
          tmpl_mem[tmpl_cnt] = pix;
          tmpl_total += pix;
          tmpl_cnt++;
          if (tmpl_cnt == TAPS) tmpl_mean = tmpl_total / TAPS;
        end
        return 0;
      end
      KIND_PIX: begin
        cols = clamp_reg(cols_reg, MAX_COLS);
        rows = clamp_reg(rows_reg, ROW_LIMIT);
        if (fs) begin
          row_cnt = 0;
          col_cnt = 0;
          peak_max = 0;
          peak_min = 0;
        end
        if (row_cnt >= rows) return 0;
        if (col_cnt >= cols) col_cnt = 0;
        rr = row_cnt;
        cc = col_cnt;
        line_mem[(rr % TR) * MAX_COLS + cc] = pix;
        col_cnt++;
        if (col_cnt >= cols) begin
          col_cnt = 0;
          row_cnt++;
        end
        if (rr + 1 < TR || cc + 1 < TC) return 0;
        acc = 0;
        for (int i = 0; i < TR; i++)
          for (int j = 0; j < TC; j++)
            acc += (longint'(tmpl_mem[i*TC + j]) - longint'(tmpl_mean)) *
                   longint'(line_mem[((rr + 1 + i) % TR) * MAX_COLS + cc + 1 + j - TC]);
        s = acc > 16777215 ? 16777215 : (acc < -16777216 ? -16777216 : acc);
        if (peak_max < s) peak_max = s;
        if (peak_min > s) peak_min = s;
        r.kind = 1'b0;
        r.sum  = s[SUM_W-1:0];
        r.row  = POS_W'(rr - TR / 2);
        r.col  = POS_W'(cc - TC / 2);
        return 1;
      end
      KIND_NORM: begin
        rng = peak_max - peak_min;
        r.kind = 1'b1;
        if (rng == 0) begin
          r.zero = 1'b1;
        end else begin
          num = longint'(rsum) - peak_min;
          if (num > 0) begin
            q = (255 * num) / rng;
            r.norm = q > 255 ? 8'd255 : q[7:0];
          end
        end
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  always @(posedge clk_i) begin
    result_t r;
    bit      has;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      has = filter_step(kind_i, pixel_i, raw_sum_i, frame_start_i, r);
      if (typed_now) expected_q.push_back(typed_res);
      else if (has) expected_q.push_back(r);
    end
  end

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report("unexpected word", 1, 0);
      end else begin
        e = expected_q.pop_front();
        if (out_kind_o !== e.kind) report("out_kind", out_kind_o, e.kind);
        if (corr_sum_o !== e.sum) report("corr_sum", corr_sum_o, e.sum);
        if (centre_row_o !== e.row) report("centre_row", centre_row_o, e.row);
        if (centre_col_o !== e.col) report("centre_col", centre_col_o, e.col);
        if (norm_pixel_o !== e.norm) report("norm_pixel", norm_pixel_o, e.norm);
        if (range_zero_o !== e.zero) report("range_zero", range_zero_o, e.zero);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        n = 600;
      end else begin
        n = rx_idle ? $urandom_range(0, 16) : 0;
      end
      out_stall_i = 1'b1;
      repeat (n) @(negedge clk_i);
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_word(kind_e kind, logic [7:0] pix, logic signed [SUM_W-1:0] rsum,
                           logic fs, bit typed = 1'b0, result_t res = '0);
    int n;
    n = tx_idle ? $urandom_range(0, 16) : 0;
    if (n > 0) begin
      in_valid_i = 1'b0;
      repeat (n) @(negedge clk_i);
    end
    kind_i = kind;
    pixel_i = pix;
    raw_sum_i = rsum;
    frame_start_i = fs;
    typed_now = typed;
    typed_res = res;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    typed_now = 1'b0;
    if (kind != KIND_NONE) words_sent++;
  endtask

  task automatic write_reg(cfg_e idx, logic [CFG_W-1:0] val);
    in_valid_i = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    if (idx == CFG_COLS) cols_reg = val;
    else rows_reg = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic load_template(int n, int style);
    logic [7:0] p;
    for (int k = 0; k < n; k++) begin
      p = style == 1 ? 8'd255 : (style == 2 ? 8'd0 : 8'($urandom));
      send_word(KIND_TMPL, p, 25'($urandom), k == 0);
    end
  endtask

  task automatic send_frame(int npix, int style);
    logic [7:0] p;
    logic [7:0] base;
    base = 8'($urandom);
    for (int k = 0; k < npix; k++) begin
      if ($urandom_range(0, 39) == 0)
        send_word(KIND_NONE, 8'($urandom), SUM_W'($urandom), 1'($urandom));
      case (style)
        1: p = base;
        2: p = 8'($urandom_range(0, 3));
        default: p = 8'($urandom);
      endcase
      send_word(KIND_PIX, p, 25'($urandom), k == 0);
    end
  endtask

  task automatic send_norms(int n);
    logic signed [SUM_W-1:0] v;
    longint lo, hi;
    for (int k = 0; k < n; k++) begin
      lo = peak_min - 50;
      hi = peak_max + 50;
      if ($urandom_range(0, 3) == 0) v = SUM_W'($urandom);
      else v = SUM_W'(lo + $urandom_range(0, int'(hi - lo)));
      send_word(KIND_NORM, 8'($urandom), v, 1'($urandom));
    end
  endtask

  stim_row_t directed [] = '{
    '{KIND_NORM, 8'd0,   25'sd16777215,  1'b0, 1'b1, '{1'b1, '0, '0, '0, 8'd0, 1'b1}},
    '{KIND_NORM, 8'd255, -25'sd16777216, 1'b1, 1'b1, '{1'b1, '0, '0, '0, 8'd0, 1'b1}},
    '{KIND_NONE, 8'd255, 25'sd0,         1'b1, 1'b0, '0},
    '{KIND_TMPL, 8'd255, 25'sd0,         1'b1, 1'b0, '0},
    '{KIND_TMPL, 8'd0,   -25'sd1,        1'b0, 1'b0, '0},
    '{KIND_TMPL, 8'd128, 25'sd0,         1'b0, 1'b0, '0},
    '{KIND_PIX,  8'd255, 25'sd0,         1'b1, 1'b0, '0},
    '{KIND_PIX,  8'd0,   25'sd0,         1'b0, 1'b0, '0},
    '{KIND_PIX,  8'd170, 25'sd0,         1'b0, 1'b0, '0},
    '{KIND_NORM, 8'd0,   25'sd0,         1'b0, 1'b1, '{1'b1, '0, '0, '0, 8'd0, 1'b1}},
    '{KIND_NONE, 8'd0,   -25'sd1,        1'b0, 1'b0, '0},
    '{KIND_NORM, 8'd85,  -25'sd1,        1'b1, 1'b1, '{1'b1, '0, '0, '0, 8'd0, 1'b1}}
  };

  initial begin
    int cols, rows, npix, phase;
    tmpl_total = 0; tmpl_mean = 0; tmpl_cnt = 0;
    row_cnt = 0; col_cnt = 0; peak_max = 0; peak_min = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i])
      send_word(directed[i].kind, directed[i].pix, directed[i].sum, directed[i].fs,
                directed[i].typed, directed[i].res);

    // degenerate sizes: both registers clamp up to one
    write_reg(CFG_COLS, 11'd0);
    write_reg(CFG_ROWS, 11'd0);
    send_frame(6, 0);
    send_norms(2);

    // smallest legal frame, one full template
    write_reg(CFG_COLS, 11'd9);
    write_reg(CFG_ROWS, 11'd15);
    load_template(TAPS, 0);
    send_frame(9 * 15 + 4, 0);
    send_norms(4);

    // row register clamps down, partial frame
    write_reg(CFG_ROWS, 11'd2047);
    load_template(TAPS, 1);
    send_frame(9 * 17, 0);
    send_norms(3);

    // widest line, rows at minimum
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    write_reg(CFG_COLS, 11'd2047);
    write_reg(CFG_ROWS, 11'd15);
    load_template(TAPS + 3, 0);
    send_frame(40, 0);
    send_norms(2);

    phase = 0;
    while (words_sent < 1500) begin
      tx_idle = $urandom_range(0, 2) != 0;
      rx_idle = $urandom_range(0, 2) != 0;
      if (phase == 0 || $urandom_range(0, 2) == 0) begin
        write_reg(CFG_COLS, 11'($urandom_range(9, 14)));
        write_reg(CFG_ROWS, 11'($urandom_range(15, 17)));
      end
      cols = clamp_reg(cols_reg, MAX_COLS);
      rows = clamp_reg(rows_reg, ROW_LIMIT);
      case ($urandom_range(0, 5))
        0: load_template($urandom_range(1, TAPS - 1), 0);
        1: load_template(TAPS + $urandom_range(1, 5), $urandom_range(0, 2));
        2, 3: load_template(TAPS, $urandom_range(0, 3) == 0 ? 1 : 0);
        default: ;
      endcase
      if (phase == 1) hold_req = 1'b1;
      npix = cols * rows;
      case ($urandom_range(0, 9))
        0: npix = npix / 2;
        1, 2: npix = npix + $urandom_range(1, 6);
        default: ;
      endcase
      send_frame(npix, $urandom_range(0, 5) == 0 ? 1 : ($urandom_range(0, 4) == 0 ? 2 : 0));
      send_norms($urandom_range(4, 8));
      phase++;
    end

    in_valid_i = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
